@@ hdl/psfb_pkg.sv @@
package psfb_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int MODE_W  = 3;
    localparam int COORD_W = 8;
    localparam int CHAN_W  = 8;
    localparam int FMT_W   = 3;
    localparam int SIZE_W  = 9;
    localparam int WORD_W  = 32;
    localparam int PROD_W  = 2 * CHAN_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    localparam logic [FMT_W-1:0] FMT_I4       = 3'd0;
    localparam logic [FMT_W-1:0] FMT_I8       = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_RGB888   = 3'd3;
    localparam logic [FMT_W-1:0] FMT_RGBA4444 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_RGBA8888 = 3'd5;

    localparam logic [MODE_W-1:0] MODE_WR_INDEX = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WR_COLOR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLEND    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RD_INDEX = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RD_COLOR = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DITHER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

    localparam logic [2:0] DITH8 [64] = '{
        3'd1, 3'd6, 3'd2, 3'd7, 3'd1, 3'd6, 3'd2, 3'd7,
        3'd4, 3'd2, 3'd5, 3'd4, 3'd4, 3'd3, 3'd6, 3'd4,
        3'd1, 3'd7, 3'd1, 3'd6, 3'd2, 3'd7, 3'd1, 3'd7,
        3'd5, 3'd3, 3'd5, 3'd3, 3'd5, 3'd4, 3'd5, 3'd3,
        3'd1, 3'd6, 3'd2, 3'd7, 3'd1, 3'd6, 3'd2, 3'd7,
        3'd4, 3'd3, 3'd6, 3'd4, 3'd4, 3'd2, 3'd6, 3'd4,
        3'd2, 3'd7, 3'd1, 3'd7, 3'd2, 3'd7, 3'd1, 3'd6,
        3'd5, 3'd3, 3'd5, 3'd3, 3'd5, 3'd3, 3'd5, 3'd3
    };

    localparam logic [1:0] DITH4 [64] = '{
        2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3,
        2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd1, 2'd3, 2'd2,
        2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3,
        2'd2, 2'd2, 2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3,
        2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd1, 2'd3, 2'd2,
        2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3, 2'd1, 2'd3,
        2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2
    };

    localparam logic [3:0] DITH16 [64] = '{
        4'd1,  4'd12, 4'd4,  4'd15, 4'd1,  4'd13, 4'd4,  4'd15,
        4'd8,  4'd4,  4'd11, 4'd7,  4'd9,  4'd5,  4'd12, 4'd8,
        4'd3,  4'd14, 4'd2,  4'd13, 4'd3,  4'd15, 4'd2,  4'd14,
        4'd10, 4'd6,  4'd9,  4'd5,  4'd11, 4'd7,  4'd10, 4'd6,
        4'd1,  4'd12, 4'd4,  4'd15, 4'd1,  4'd12, 4'd4,  4'd15,
        4'd9,  4'd5,  4'd12, 4'd8,  4'd8,  4'd5,  4'd11, 4'd8,
        4'd3,  4'd14, 4'd2,  4'd13, 4'd3,  4'd14, 4'd2,  4'd13,
        4'd11, 4'd7,  4'd10, 4'd6,  4'd10, 4'd7,  4'd9,  4'd6
    };

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [CHAN_W-1:0]  pixel_index;
        logic [CHAN_W-1:0]  red_in;
        logic [CHAN_W-1:0]  green_in;
        logic [CHAN_W-1:0]  blue_in;
        logic [CHAN_W-1:0]  alpha_in;
    } t_req;

    typedef struct packed {
        logic [FMT_W-1:0] pixel_format;
        logic             dither_enable;
        logic             in_range;
    } t_ctl;

    typedef struct packed {
        logic              ok;
        logic [CHAN_W-1:0] index_out;
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic [CHAN_W-1:0] alpha_out;
    } t_res;

    function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] v,
                                                  input logic [3:0] d);
        logic [CHAN_W:0] s;
        s = {1'b0, v} + {5'b0, d};
        return s[CHAN_W] ? 8'hFF : s[CHAN_W-1:0];
    endfunction

    // Exact floor(p / 255) for any product of two eight-bit values.
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        t = {1'b0, p} + 17'd1 + {9'b0, p[PROD_W-1:CHAN_W]};
        return t[PROD_W-1:CHAN_W];
    endfunction

    function automatic logic [WORD_W-1:0] pack565(input logic [CHAN_W-1:0] r,
                                                  input logic [CHAN_W-1:0] g,
                                                  input logic [CHAN_W-1:0] b);
        return {16'b0, r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic logic [WORD_W-1:0] pack4444(input logic [CHAN_W-1:0] r,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] b,
                                                   input logic [CHAN_W-1:0] a);
        return {16'b0, r[7:4], g[7:4], b[7:4], a[7:4]};
    endfunction

endpackage

@@ hdl/psfb_store.sv @@
module psfb_store #(
    parameter int DEPTH  = psfb_pkg::MAX_WIDTH_DEF * psfb_pkg::MAX_HEIGHT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_addr,
    input  logic [psfb_pkg::WORD_W-1:0] i_wdata,
    output logic [psfb_pkg::WORD_W-1:0] o_rdata
);

    logic [psfb_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [psfb_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/psfb_pix.sv @@
module psfb_pix (
    input  logic                        i_clk,
    input  logic                        i_mul_en,
    input  psfb_pkg::t_req              i_req,
    input  psfb_pkg::t_ctl              i_ctl,
    input  logic [psfb_pkg::WORD_W-1:0] i_rdata,
    output logic                        o_we,
    output logic [psfb_pkg::WORD_W-1:0] o_wdata,
    output psfb_pkg::t_res              o_res
);

    logic [psfb_pkg::PROD_W-1:0] r_pd [3];
    logic [psfb_pkg::PROD_W-1:0] r_ps [3];
    logic [psfb_pkg::CHAN_W-1:0] dst [3];
    logic [psfb_pkg::CHAN_W-1:0] src [3];
    logic [psfb_pkg::CHAN_W-1:0] mixed [3];
    logic [psfb_pkg::CHAN_W-1:0] inv_a;
    logic [psfb_pkg::CHAN_W:0]   sum [3];
    logic [5:0]                  di;
    logic [psfb_pkg::WORD_W-1:0] dith_word;
    logic [psfb_pkg::WORD_W-1:0] v;
    logic                        indexed;
    logic                        color;
    logic                        is_wr_idx;
    logic                        is_rd_idx;
    logic                        is_wr_col;
    logic                        is_rd_col;
    logic                        dith;
    logic [psfb_pkg::FMT_W-1:0]  fmt;
    logic [psfb_pkg::CHAN_W-1:0] r4;
    logic [psfb_pkg::CHAN_W-1:0] r5;
    logic [psfb_pkg::CHAN_W-1:0] g6;
    logic [psfb_pkg::CHAN_W-1:0] b5;

    assign v     = i_rdata;
    assign fmt   = i_ctl.pixel_format;
    assign inv_a = 8'd255 - i_req.alpha_in;
    assign di    = {i_req.y_pos[2:0], i_req.x_pos[2:0]};

    assign indexed = (fmt == psfb_pkg::FMT_I4) || (fmt == psfb_pkg::FMT_I8);
    assign color   = (fmt == psfb_pkg::FMT_RGB565) || (fmt == psfb_pkg::FMT_RGB888) ||
                     (fmt == psfb_pkg::FMT_RGBA4444) || (fmt == psfb_pkg::FMT_RGBA8888);
    assign is_wr_idx = i_ctl.in_range && indexed && (i_req.mode == psfb_pkg::MODE_WR_INDEX);
    assign is_rd_idx = i_ctl.in_range && indexed && (i_req.mode == psfb_pkg::MODE_RD_INDEX);
    assign is_wr_col = i_ctl.in_range && color &&
                       ((i_req.mode == psfb_pkg::MODE_WR_COLOR) ||
                        (i_req.mode == psfb_pkg::MODE_BLEND));
    assign is_rd_col = i_ctl.in_range && color && (i_req.mode == psfb_pkg::MODE_RD_COLOR);
    assign dith = i_ctl.dither_enable &&
                  ((fmt == psfb_pkg::FMT_RGB565) || (fmt == psfb_pkg::FMT_RGBA4444));

    assign src[0] = i_req.red_in;
    assign src[1] = i_req.green_in;
    assign src[2] = i_req.blue_in;

    always_comb begin
        case (fmt)
            psfb_pkg::FMT_RGBA4444: begin
                dst[0] = {v[15:12], 4'b0};
                dst[1] = {v[11:8], 4'b0};
                dst[2] = {v[7:4], 4'b0};
            end
            psfb_pkg::FMT_RGB888: begin
                dst[0] = v[23:16];
                dst[1] = v[15:8];
                dst[2] = v[7:0];
            end
            default: begin
                dst[0] = v[31:24];
                dst[1] = v[23:16];
                dst[2] = v[15:8];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pd[k] <= {{psfb_pkg::CHAN_W{1'b0}}, dst[k]} *
                           {{psfb_pkg::CHAN_W{1'b0}}, inv_a};
                r_ps[k] <= {{psfb_pkg::CHAN_W{1'b0}}, src[k]} *
                           {{psfb_pkg::CHAN_W{1'b0}}, i_req.alpha_in};
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k]   = {1'b0, psfb_pkg::div255(r_pd[k])} + {1'b0, psfb_pkg::div255(r_ps[k])};
            mixed[k] = sum[k][psfb_pkg::CHAN_W] ? 8'hFF : sum[k][psfb_pkg::CHAN_W-1:0];
        end
    end

    always_comb begin
        if (fmt == psfb_pkg::FMT_RGB565) begin
            dith_word = psfb_pkg::pack565(
                psfb_pkg::sat_add(i_req.red_in, {1'b0, psfb_pkg::DITH8[di]}),
                psfb_pkg::sat_add(i_req.green_in, {2'b0, psfb_pkg::DITH4[di]}),
                psfb_pkg::sat_add(i_req.blue_in, {1'b0, psfb_pkg::DITH8[di]}));
        end else begin
            dith_word = psfb_pkg::pack4444(
                psfb_pkg::sat_add(i_req.red_in, psfb_pkg::DITH16[di]),
                psfb_pkg::sat_add(i_req.green_in, psfb_pkg::DITH16[di]),
                psfb_pkg::sat_add(i_req.blue_in, psfb_pkg::DITH16[di]),
                psfb_pkg::sat_add(i_req.alpha_in, psfb_pkg::DITH16[di]));
        end
    end

    always_comb begin
        o_we    = is_wr_idx || is_wr_col;
        o_wdata = '0;
        if (is_wr_idx) begin
            o_wdata = (fmt == psfb_pkg::FMT_I4) ? {28'b0, i_req.pixel_index[3:0]}
                                                : {24'b0, i_req.pixel_index};
        end else if (dith || (i_req.mode == psfb_pkg::MODE_BLEND &&
                              fmt == psfb_pkg::FMT_RGB565)) begin
            o_wdata = dith_word;
        end else if (i_req.mode == psfb_pkg::MODE_WR_COLOR) begin
            case (fmt)
                psfb_pkg::FMT_RGB565:
                    o_wdata = psfb_pkg::pack565(i_req.red_in, i_req.green_in, i_req.blue_in);
                psfb_pkg::FMT_RGB888:
                    o_wdata = {8'b0, i_req.red_in, i_req.green_in, i_req.blue_in};
                psfb_pkg::FMT_RGBA4444:
                    o_wdata = psfb_pkg::pack4444(i_req.red_in, i_req.green_in,
                                                 i_req.blue_in, i_req.alpha_in);
                default:
                    o_wdata = {i_req.red_in, i_req.green_in, i_req.blue_in, i_req.alpha_in};
            endcase
        end else if (fmt == psfb_pkg::FMT_RGBA4444) begin
            o_wdata = {16'b0, mixed[0][7:4], mixed[1][7:4], mixed[2][7:4], v[3:0]};
        end else if (fmt == psfb_pkg::FMT_RGB888) begin
            o_wdata = {8'b0, mixed[0], mixed[1], mixed[2]};
        end else begin
            o_wdata = {mixed[0], mixed[1], mixed[2], v[7:0]};
        end
    end

    assign r4 = {v[15:12], v[15:12]};
    assign r5 = {v[15:11], v[15:13]};
    assign g6 = {v[10:5], v[10:9]};
    assign b5 = {v[4:0], v[4:2]};

    always_comb begin
        o_res    = '0;
        o_res.ok = is_wr_idx || is_rd_idx || is_wr_col || is_rd_col;
        if (is_rd_idx) begin
            o_res.index_out = (fmt == psfb_pkg::FMT_I4) ? {4'b0, v[3:0]} : v[7:0];
        end
        if (is_rd_col) begin
            o_res.alpha_out = 8'hFF;
            case (fmt)
                psfb_pkg::FMT_RGB565: begin
                    o_res.red_out   = r5;
                    o_res.green_out = g6;
                    o_res.blue_out  = b5;
                end
                psfb_pkg::FMT_RGB888: begin
                    o_res.red_out   = v[23:16];
                    o_res.green_out = v[15:8];
                    o_res.blue_out  = v[7:0];
                end
                psfb_pkg::FMT_RGBA4444: begin
                    o_res.red_out   = r4;
                    o_res.green_out = {v[11:8], v[11:8]};
                    o_res.blue_out  = {v[7:4], v[7:4]};
                    o_res.alpha_out = {v[3:0], v[3:0]};
                end
                default: begin
                    o_res.red_out   = v[31:24];
                    o_res.green_out = v[23:16];
                    o_res.blue_out  = v[15:8];
                    o_res.alpha_out = v[7:0];
                end
            endcase
        end
    end

endmodule

@@ hdl/pixel_store_format_blend_top.sv @@
// Pixel frame store with format conversion and alpha blending. Each request
// passes through accept, store read, multiply and write back with the result
// registered, an order set by the read-modify-write through the single port
// of the frame memory, so a new request is taken only after the last write
// back and each result is offered from an output register; a result that is
// not taken holds the next write back. After reset the store is swept to
// zero, one entry per cycle, over all MAX_WIDTH*MAX_HEIGHT entries (65536 by
// default) while no request is taken; configuration writes are taken at any
// time and always have ready high.
module pixel_store_format_blend_top #(
    parameter int MAX_WIDTH  = psfb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = psfb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // mode[2:0], x_pos[10:3], y_pos[18:11], pixel_index[26:19], red_in[34:27],
    // green_in[42:35], blue_in[50:43], alpha_in[58:51], zeros above.
    input  logic [psfb_pkg::IN_DATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // ok[0], index_out[8:1], red_out[16:9], green_out[24:17], blue_out[32:25],
    // alpha_out[40:33], zeros above.
    output logic [psfb_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [psfb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [psfb_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]                       r_state;
    logic [ADDR_W-1:0]                r_clr_addr;
    logic [ADDR_W-1:0]                r_addr;
    psfb_pkg::t_req                   r_req;
    logic                             r_in_range;
    logic [psfb_pkg::FMT_W-1:0]       r_fmt;
    logic                             r_dither;
    logic [psfb_pkg::SIZE_W-1:0]      r_width;
    logic [psfb_pkg::SIZE_W-1:0]      r_height;
    logic                             r_out_valid;
    psfb_pkg::t_res                   r_out;

    psfb_pkg::t_req                   in_req;
    psfb_pkg::t_ctl                   ctl;
    psfb_pkg::t_res                   res;
    logic                             in_take;
    logic                             fin_go;
    logic                             pix_we;
    logic [psfb_pkg::WORD_W-1:0]      pix_wdata;
    logic [psfb_pkg::WORD_W-1:0]      mem_rdata;
    logic                             mem_en;
    logic                             mem_we;
    logic [ADDR_W-1:0]                mem_addr;
    logic [psfb_pkg::WORD_W-1:0]      mem_wdata;
    logic                             n_in_range;
    logic [ADDR_W-1:0]                n_addr;

    assign in_req     = {i_s_tdata[2:0], i_s_tdata[10:3], i_s_tdata[18:11],
                         i_s_tdata[26:19], i_s_tdata[34:27], i_s_tdata[42:35],
                         i_s_tdata[50:43], i_s_tdata[58:51]};
    assign o_s_tready = (r_state == ST_IDLE);
    assign in_take    = i_s_tvalid && o_s_tready;
    assign fin_go     = (r_state == ST_FIN) && (!r_out_valid || i_m_tready);
    assign o_cfg_ready = 1'b1;

    assign n_in_range = ({1'b0, in_req.x_pos} < r_width) &&
                        ({1'b0, in_req.y_pos} < r_height) &&
                        (32'(in_req.x_pos) < MAX_WIDTH) &&
                        (32'(in_req.y_pos) < MAX_HEIGHT);
    assign n_addr = ADDR_W'(32'(in_req.y_pos) * MAX_WIDTH + 32'(in_req.x_pos));

    assign ctl.pixel_format  = r_fmt;
    assign ctl.dither_enable = r_dither;
    assign ctl.in_range      = r_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= '0;
            r_dither <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                psfb_pkg::CFG_FORMAT: r_fmt    <= i_cfg_data[psfb_pkg::FMT_W-1:0];
                psfb_pkg::CFG_DITHER: r_dither <= i_cfg_data[0];
                psfb_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                psfb_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr_addr <= '0;
        end else begin
            unique case (r_state)
                ST_CLR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_take) begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD:  r_state <= ST_MUL;
                ST_MUL: r_state <= ST_FIN;
                ST_FIN: begin
                    if (fin_go) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req      <= in_req;
            r_in_range <= n_in_range;
            r_addr     <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out <= res;
        end
    end

    always_comb begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = r_addr;
        mem_wdata = pix_wdata;
        if (r_state == ST_CLR) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == ST_RD) begin
            mem_en = r_in_range;
        end else if (fin_go && pix_we) begin
            mem_en = 1'b1;
            mem_we = 1'b1;
        end
    end

    psfb_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    psfb_pix u_pix (
        .i_clk    (i_clk),
        .i_mul_en (r_state == ST_MUL),
        .i_req    (r_req),
        .i_ctl    (ctl),
        .i_rdata  (mem_rdata),
        .o_we     (pix_we),
        .o_wdata  (pix_wdata),
        .o_res    (res)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out.alpha_out, r_out.blue_out, r_out.green_out,
                         r_out.red_out, r_out.index_out, r_out.ok};

`ifndef SYNTHESIS
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_RD || r_state == ST_MUL) |-> !mem_we)
        else $error("frame store written outside clear or write back");

    a_take_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == ST_RD))
        else $error("accepted request did not start a store read");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLR) |-> (!o_m_tvalid && !o_s_tready))
        else $error("traffic during store clear");

    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_go && pix_we) |=> (o_m_tvalid && o_m_tdata[0]))
        else $error("store written for a request that reports failure");
`endif

endmodule
